// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the LED command packet parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LCPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition in one cycle that requires another in the same cycle.
`define LCPP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition in one cycle that requires another in the next cycle.
`define LCPP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lcpp_pkg.sv -----
// Types, codes and reset constants of the LED command packet parser.
package lcpp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COLOR,
    PH_TIMEOUT,
    PH_TAIL
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_VERSION,
    EV_BAD_HEADER,
    EV_TIMEOUT,
    EV_RANGE,
    EV_BAD_TAIL,
    EV_COLOR,
    EV_LIMIT
  } ev_t;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_COLOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIMEOUT   = 3'd5;

  localparam logic [7:0] RST_HEADER_COLOR   = 8'd160;
  localparam logic [7:0] RST_HEADER_TIMEOUT = 8'd161;
  localparam logic [7:0] RST_TAIL_BYTE      = 8'd192;
  localparam logic [4:0] RST_TIMEOUT_LOW    = 5'd1;
  localparam logic [4:0] RST_TIMEOUT_HIGH   = 5'd20;
  localparam logic [5:0] RST_LONG_TIMEOUT   = 6'd30;
  localparam logic [4:0] RST_LIMIT          = 5'd5;

  localparam logic [7:0] VERSION_BYTE = 8'h76;
  localparam logic [5:0] SEC_MAX      = 6'd63;

  typedef struct packed {
    logic [7:0] hdr_colour;
    logic [7:0] hdr_limit;
    logic [7:0] close_byte;
    logic [4:0] timeout_low;
    logic [4:0] timeout_high;
    logic [5:0] long_timeout;
  } cfg_t;

  typedef struct packed {
    ev_t        ev;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [4:0] byte_timeout;
  } result_t;

endpackage

// ----- rtl/led_command_packet_parser.sv -----
// LED command packet parser, top level.
//
// The parser takes one item per clock cycle on the s_ stream, when s_tready is
// high: a byte from the serial link or a one-second tick, told apart by s_tuser.
// Every accepted item produces exactly one result transaction on the m_
// stream, in order: an event code in m_tuser and, with it, the applied colour
// bytes (zero unless the event is "colour applied") and the inter-byte timeout
// limit that holds after the item. A colour packet is its header byte, three
// colour bytes and the tail byte; a timeout packet is its header byte, one
// value byte within the programmed range and the tail byte. The byte 0x76 in
// idle asks for the version reply, and any other unexpected header is reported
// as a bad header. Ticks count seconds since the last packet byte; a packet
// that stalls too long is dropped with a timeout event. Each item passes through
// the packet state machine, and its result is registered in a two-entry output
// buffer (output register and skid stage), so the parser keeps taking items
// while one result waits; s_tready falls only when both entries are full. The
// configuration registers are written through the cfg_ channel, which is
// always ready, and should only be written while no transaction is in flight.
`include "assert_macros.svh"

module led_command_packet_parser (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lcpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  // Input stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
  input  logic [0:0]                     s_tuser,   // [0] command: 0 byte, 1 tick
  // Result stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,   // [7:0] red, [15:8] green,
                                                    // [23:16] blue,
                                                    // [28:24] byte_timeout,
                                                    // [31:29] zero
  output logic [2:0]                     m_tuser    // [2:0] event_res
);
  import lcpp_pkg::*;

  cfg_t    cfg;
  logic    accept;
  result_t push_res;
  result_t head_res;

  // The register file takes every write; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hdr_colour   <= RST_HEADER_COLOR;
      cfg.hdr_limit    <= RST_HEADER_TIMEOUT;
      cfg.close_byte   <= RST_TAIL_BYTE;
      cfg.timeout_low  <= RST_TIMEOUT_LOW;
      cfg.timeout_high <= RST_TIMEOUT_HIGH;
      cfg.long_timeout <= RST_LONG_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER_COLOR:   cfg.hdr_colour   <= cfg_data;
        CFG_HEADER_TIMEOUT: cfg.hdr_limit    <= cfg_data;
        CFG_TAIL_BYTE:      cfg.close_byte   <= cfg_data;
        CFG_TIMEOUT_LOW:    cfg.timeout_low  <= cfg_data[4:0];
        CFG_TIMEOUT_HIGH:   cfg.timeout_high <= cfg_data[4:0];
        CFG_LONG_TIMEOUT:   cfg.long_timeout <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // An item is taken whenever the result buffer has room for its result.
  assign accept = s_tvalid && s_tready;

  lcpp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .command (s_tuser[0]),
    .rx_byte (s_tdata),
    .res     (push_res)
  );

  lcpp_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (push_res),
    .push_ready (s_tready),
    .head_valid (m_tvalid),
    .head_data  (head_res),
    .pop_ready  (m_tready)
  );

  assign m_tuser = head_res.ev;
  assign m_tdata = {3'd0, head_res.byte_timeout, head_res.blue, head_res.green,
                    head_res.red};

  // A tick can only ever report nothing or a timeout.
  `LCPP_ASSERT_IMP(a_tick_events, accept && s_tuser[0], push_res.ev == EV_NONE || push_res.ev == EV_TIMEOUT, "tick produced a byte event")

  // Colour bytes are shown only with the colour-applied event.
  `LCPP_ASSERT_IMP(a_colour_gated, m_tvalid && m_tuser != EV_COLOR, m_tdata[23:0] == 24'd0, "colour bytes without colour event")

  // Every accepted transaction leaves a result visible in the next cycle.
  `LCPP_ASSERT_NXT(a_result_shown, accept, m_tvalid, "accepted item left no result")

  // The timeout limit moves only with a limit-updated event.
  `LCPP_ASSERT_NXT(a_limit_steady, m_tvalid && m_tready && s_tvalid && s_tready && push_res.ev != EV_LIMIT && head_res.ev != EV_LIMIT, m_tdata[28:24] == $past(push_res.byte_timeout), "limit changed without update")

endmodule

// ----- rtl/lcpp_core.sv -----
// Packet state machine: takes one item per cycle while accept is high and produces its result.
module lcpp_core (
  input  logic              clk,
  input  logic              rst,
  input  lcpp_pkg::cfg_t    cfg,
  input  logic              accept,
  input  logic              command,
  input  logic [7:0]        rx_byte,
  output lcpp_pkg::result_t res
);
  import lcpp_pkg::*;

  phase_t     phase, phase_next;
  logic [1:0] byte_position, byte_position_next;
  logic       tail_from_timeout, tail_from_timeout_next;
  logic [5:0] elapsed_seconds, elapsed_seconds_next;
  logic [4:0] limit_seconds, limit_seconds_next;
  logic [4:0] pending_value, pending_value_next;
  logic [7:0] color_store [3];
  logic [7:0] color_store_next [3];

  logic [5:0] elapsed_inc;
  logic [5:0] tick_limit;
  logic       applied;
  ev_t        ev;

  always_comb begin
    phase_next             = phase;
    byte_position_next     = byte_position;
    tail_from_timeout_next = tail_from_timeout;
    elapsed_seconds_next   = elapsed_seconds;
    limit_seconds_next     = limit_seconds;
    pending_value_next     = pending_value;
    color_store_next       = color_store;
    applied                = 1'b0;
    ev                     = EV_NONE;
    elapsed_inc = (elapsed_seconds == SEC_MAX) ? elapsed_seconds
                                               : 6'(elapsed_seconds + 6'd1);
    // Colour packets use the programmed limit, timeout packets the long one.
    tick_limit = (phase == PH_COLOR || (phase == PH_TAIL && !tail_from_timeout)) ?
                 {1'b0, limit_seconds} : cfg.long_timeout;

    if (accept) begin
      if (command) begin
        elapsed_seconds_next = elapsed_inc;
        if (phase != PH_IDLE && elapsed_inc >= tick_limit) begin
          phase_next         = PH_IDLE;
          byte_position_next = 2'd0;
          ev                 = EV_TIMEOUT;
        end
      end else begin
        case (phase)
          PH_IDLE: begin
            if (rx_byte == cfg.hdr_colour) begin
              phase_next           = PH_COLOR;
              byte_position_next   = 2'd0;
              elapsed_seconds_next = 6'd0;
            end else if (rx_byte == cfg.hdr_limit) begin
              phase_next           = PH_TIMEOUT;
              elapsed_seconds_next = 6'd0;
            end else if (rx_byte == VERSION_BYTE) begin
              ev = EV_VERSION;
            end else begin
              ev = EV_BAD_HEADER;
            end
          end
          PH_COLOR: begin
            elapsed_seconds_next = 6'd0;
            case (byte_position)
              2'd0:    color_store_next[0] = rx_byte;
              2'd1:    color_store_next[1] = rx_byte;
              default: color_store_next[2] = rx_byte;
            endcase
            if (byte_position >= 2'd2) begin
              byte_position_next     = 2'd0;
              tail_from_timeout_next = 1'b0;
              phase_next             = PH_TAIL;
            end else begin
              byte_position_next = 2'(byte_position + 2'd1);
            end
          end
          PH_TIMEOUT: begin
            elapsed_seconds_next = 6'd0;
            pending_value_next   = rx_byte[4:0];
            if (rx_byte >= {3'd0, cfg.timeout_low} && rx_byte <= {3'd0, cfg.timeout_high}) begin
              tail_from_timeout_next = 1'b1;
              phase_next             = PH_TAIL;
            end else begin
              phase_next         = PH_IDLE;
              byte_position_next = 2'd0;
              ev                 = EV_RANGE;
            end
          end
          default: begin
            phase_next         = PH_IDLE;
            byte_position_next = 2'd0;
            if (rx_byte != cfg.close_byte) begin
              ev = EV_BAD_TAIL;
            end else if (tail_from_timeout) begin
              limit_seconds_next = pending_value;
              ev                 = EV_LIMIT;
            end else begin
              applied = 1'b1;
              ev      = EV_COLOR;
            end
          end
        endcase
      end
    end

    res.ev           = ev;
    res.red          = applied ? color_store[0] : 8'd0;
    res.green        = applied ? color_store[1] : 8'd0;
    res.blue         = applied ? color_store[2] : 8'd0;
    res.byte_timeout = limit_seconds_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      byte_position     <= 2'd0;
      tail_from_timeout <= 1'b0;
      elapsed_seconds   <= 6'd0;
      limit_seconds     <= RST_LIMIT;
    end else begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      tail_from_timeout <= tail_from_timeout_next;
      elapsed_seconds   <= elapsed_seconds_next;
      limit_seconds     <= limit_seconds_next;
    end
  end

  // Packet payload holds no reset: it is always written before it is read.
  always_ff @(posedge clk) begin
    pending_value <= pending_value_next;
    color_store   <= color_store_next;
  end

endmodule

// ----- rtl/lcpp_out_buf.sv -----
// Two-entry result buffer: output register plus skid stage.
module lcpp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lcpp_pkg::result_t push_data,
  output logic              push_ready,
  output logic              head_valid,
  output lcpp_pkg::result_t head_data,
  input  logic              pop_ready
);
  import lcpp_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop        = head_valid && pop_ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid || pop) begin
      head_data <= skid_valid ? skid_data : push_data;
    end
    if (push && !skid_valid && head_valid && !pop) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- tb/lcpp_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts and compares every result transaction of the LED command packet parser.
module lcpp_checker
  import lcpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,
  input  logic [0:0]           s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [31:0]          m_tdata,
  input  logic [2:0]           m_tuser,
  output int                   errors,
  output int                   pending,
  output int                   n_checked,
  output logic [7:0]           ev_seen
);

  // Shadow copy of the programmed registers and of the parser state.
  cfg_t        regs;
  phase_t      ph;
  logic [1:0]  pos;
  logic [7:0]  colours [3];
  logic [7:0]  held_value;
  logic        tail_is_limit;
  logic [5:0]  secs;
  logic [4:0]  limit;

  result_t     queued_results [$];
  int          err_count = 0;
  int          checked = 0;
  logic [7:0]  seen = '0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("checker: %0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    err_count++;
  endtask

  // Advances the shadow state by one item and returns the result it causes.
  function automatic result_t parse_item(input logic tick, input logic [7:0] b);
    result_t    r;
    logic [5:0] lim;
    r    = '0;
    r.ev = EV_NONE;
    if (tick) begin
      if (secs != SEC_MAX) secs = secs + 6'd1;
      if (ph != PH_IDLE) begin
        if (ph == PH_COLOR || (ph == PH_TAIL && !tail_is_limit)) lim = {1'b0, limit};
        else lim = regs.long_timeout;
        if (secs >= lim) begin
          r.ev = EV_TIMEOUT;
          ph   = PH_IDLE;
          pos  = '0;
        end
      end
    end else begin
      case (ph)
        PH_IDLE: begin
          if (b == regs.hdr_colour) begin
            ph   = PH_COLOR;
            pos  = '0;
            secs = '0;
          end else if (b == regs.hdr_limit) begin
            ph   = PH_TIMEOUT;
            secs = '0;
          end else if (b == VERSION_BYTE) begin
            r.ev = EV_VERSION;
          end else begin
            r.ev = EV_BAD_HEADER;
          end
        end
        PH_COLOR: begin
          secs         = '0;
          colours[pos] = b;
          if (pos == 2'd2) begin
            pos           = '0;
            tail_is_limit = 1'b0;
            ph            = PH_TAIL;
          end else begin
            pos = pos + 2'd1;
          end
        end
        PH_TIMEOUT: begin
          secs       = '0;
          held_value = b;
          if (b >= {3'b000, regs.timeout_low} && b <= {3'b000, regs.timeout_high}) begin
            tail_is_limit = 1'b1;
            ph            = PH_TAIL;
          end else begin
            ph   = PH_IDLE;
            pos  = '0;
            r.ev = EV_RANGE;
          end
        end
        default: begin
          ph  = PH_IDLE;
          pos = '0;
          if (b != regs.close_byte) begin
            r.ev = EV_BAD_TAIL;
          end else if (tail_is_limit) begin
            limit = held_value[4:0];
            r.ev  = EV_LIMIT;
          end else begin
            r.ev    = EV_COLOR;
            r.red   = colours[0];
            r.green = colours[1];
            r.blue  = colours[2];
          end
        end
      endcase
    end
    r.byte_timeout = limit;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      regs.hdr_colour   = RST_HEADER_COLOR;
      regs.hdr_limit    = RST_HEADER_TIMEOUT;
      regs.close_byte   = RST_TAIL_BYTE;
      regs.timeout_low  = RST_TIMEOUT_LOW;
      regs.timeout_high = RST_TIMEOUT_HIGH;
      regs.long_timeout = RST_LONG_TIMEOUT;
      ph            = PH_IDLE;
      pos           = '0;
      colours[0]    = '0;
      colours[1]    = '0;
      colours[2]    = '0;
      held_value    = '0;
      tail_is_limit = 1'b0;
      secs          = '0;
      limit         = RST_LIMIT;
      queued_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEADER_COLOR:   regs.hdr_colour   = cfg_data;
          CFG_HEADER_TIMEOUT: regs.hdr_limit    = cfg_data;
          CFG_TAIL_BYTE:      regs.close_byte   = cfg_data;
          CFG_TIMEOUT_LOW:    regs.timeout_low  = cfg_data[4:0];
          CFG_TIMEOUT_HIGH:   regs.timeout_high = cfg_data[4:0];
          CFG_LONG_TIMEOUT:   regs.long_timeout = cfg_data[5:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        seen[m_tuser] = 1'b1;
        if (queued_results.size() == 0) begin
          report_mismatch("result with no item waiting", {m_tuser, m_tdata[28:0]}, 32'd0);
        end else begin
          want = queued_results.pop_front();
          checked++;
          if (m_tuser != want.ev)
            report_mismatch("event_res", 32'(m_tuser), 32'(want.ev));
          if (m_tdata[7:0] != want.red)
            report_mismatch("red", 32'(m_tdata[7:0]), 32'(want.red));
          if (m_tdata[15:8] != want.green)
            report_mismatch("green", 32'(m_tdata[15:8]), 32'(want.green));
          if (m_tdata[23:16] != want.blue)
            report_mismatch("blue", 32'(m_tdata[23:16]), 32'(want.blue));
          if (m_tdata[28:24] != want.byte_timeout)
            report_mismatch("byte_timeout", 32'(m_tdata[28:24]), 32'(want.byte_timeout));
          if (m_tdata[31:29] != 3'b000)
            report_mismatch("padding", 32'(m_tdata[31:29]), 32'd0);
        end
      end
      if (s_tvalid && s_tready) queued_results.push_back(parse_item(s_tuser[0], s_tdata));
    end
    errors    <= err_count;
    pending   <= queued_results.size();
    n_checked <= checked;
    ev_seen   <= seen;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Top level of the testbench: stimulus, flow control and verdict for the packet parser.
module tb;
  import lcpp_pkg::*;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_HEADER_COLOR;
  logic [7:0]           cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = '0;   // [7:0] rx_byte
  logic [0:0]           s_tuser   = '0;   // [0] command: 0 byte, 1 tick
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [31:0]          m_tdata;          // [7:0] red, [15:8] green, [23:16] blue,
                                          // [28:24] byte_timeout, [31:29] zero
  logic [2:0]           m_tuser;          // [2:0] event_res

  int         errors;
  int         pending;
  int         n_checked;
  logic [7:0] ev_seen;

  // Idling rates of the two sides, in percent of cycles.
  int tx_idle_pct = 8;
  int rx_idle_pct = 8;

  // Each increment asks the receiver for one long hold-off.
  int hold_requests = 0;

  int items_sent = 0;
  int settings   = 1;

  // The register values currently programmed, kept only to build well-formed packets.
  logic [7:0] hc = RST_HEADER_COLOR;
  logic [7:0] ht = RST_HEADER_TIMEOUT;
  logic [7:0] tl = RST_TAIL_BYTE;
  logic [4:0] lo = RST_TIMEOUT_LOW;
  logic [4:0] hi = RST_TIMEOUT_HIGH;
  logic [5:0] lt = RST_LONG_TIMEOUT;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  led_command_packet_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  lcpp_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .errors    (errors),
    .pending   (pending),
    .n_checked (n_checked),
    .ev_seen   (ev_seen)
  );

  // Receiver: m_tready is redrawn at every rising edge. A hold-off request keeps it low
  // for a long stretch, counted here, so that the two-entry output buffer fills and the
  // parser has to lower s_tready while the sender keeps offering transactions.
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done++;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offers one item and returns once the transaction has been accepted. Idle cycles
  // are drawn before the item, so a gap can fall between any two items of a packet.
  task automatic send_item(input logic tick, input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= tick;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Ticks between bytes: mostly none or a few, sometimes a burst long enough to reach
  // any of the limits, so that packets time out in every phase.
  task automatic send_gap;
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    if (roll < 75) n = 0;
    else if (roll < 92) n = $urandom_range(1, 2);
    else n = $urandom_range(0, 66);
    repeat (n) send_item(1'b1, 8'($urandom));
  endtask

  // One sequence of the random part. Most are well-formed packets with random content
  // under the registers now programmed; the rest are broken packets and noise.
  task automatic send_sequence;
    int         roll;
    logic [7:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      send_item(1'b0, hc);
      repeat (3) begin
        send_gap();
        send_item(1'b0, 8'($urandom));
      end
      send_gap();
      send_item(1'b0, ($urandom_range(0, 9) == 0) ? 8'($urandom) : tl);
    end else if (roll < 60) begin
      send_item(1'b0, ht);
      send_gap();
      if (lo <= hi && $urandom_range(0, 4) != 0) v = 8'($urandom_range(hi, lo));
      else v = 8'($urandom);
      send_item(1'b0, v);
      send_gap();
      send_item(1'b0, ($urandom_range(0, 9) == 0) ? 8'($urandom) : tl);
    end else if (roll < 70) begin
      send_item(1'b0, VERSION_BYTE);
    end else if (roll < 80) begin
      // A packet cut short: whatever follows is taken as the rest of it.
      send_item(1'b0, ($urandom_range(0, 1) == 0) ? hc : ht);
      repeat ($urandom_range(0, 2)) send_item(1'b0, 8'($urandom));
    end else begin
      send_item(1'($urandom_range(0, 1)), 8'($urandom));
    end
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic wait_for_results;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Reprograms all six registers once the parser has gone quiet.
  task automatic load_config(input logic [7:0] new_hc, input logic [7:0] new_ht,
                             input logic [7:0] new_tl, input logic [4:0] new_lo,
                             input logic [4:0] new_hi, input logic [5:0] new_lt);
    wait_for_results();
    write_reg(CFG_HEADER_COLOR, new_hc);
    write_reg(CFG_HEADER_TIMEOUT, new_ht);
    write_reg(CFG_TAIL_BYTE, new_tl);
    write_reg(CFG_TIMEOUT_LOW, {3'b000, new_lo});
    write_reg(CFG_TIMEOUT_HIGH, {3'b000, new_hi});
    write_reg(CFG_LONG_TIMEOUT, {2'b00, new_lt});
    cfg_valid <= 1'b0;
    hc = new_hc;
    ht = new_ht;
    tl = new_tl;
    lo = new_lo;
    hi = new_hi;
    lt = new_lt;
    settings++;
  endtask

  task automatic run_random(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_sequence();
  endtask

  initial begin
    logic [7:0] r_hc;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset values of the registers.
    send_item(1'b0, VERSION_BYTE);
    send_item(1'b0, 8'h00);
    // Colour packet with the extreme byte values.
    send_item(1'b0, RST_HEADER_COLOR);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h5A);
    send_item(1'b0, RST_TAIL_BYTE);
    // Timeout packets at both edges of the accepted range, which leaves the limit at one.
    send_item(1'b0, RST_HEADER_TIMEOUT);
    send_item(1'b0, {3'b000, RST_TIMEOUT_HIGH});
    send_item(1'b0, RST_TAIL_BYTE);
    send_item(1'b0, RST_HEADER_TIMEOUT);
    send_item(1'b0, {3'b000, RST_TIMEOUT_LOW});
    send_item(1'b0, RST_TAIL_BYTE);
    // Values just outside the range on either side.
    send_item(1'b0, RST_HEADER_TIMEOUT);
    send_item(1'b0, {3'b000, RST_TIMEOUT_LOW} - 8'd1);
    send_item(1'b0, RST_HEADER_TIMEOUT);
    send_item(1'b0, {3'b000, RST_TIMEOUT_HIGH} + 8'd1);
    // A wrong tail byte.
    send_item(1'b0, RST_HEADER_COLOR);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'h02);
    send_item(1'b0, 8'h03);
    send_item(1'b0, ~RST_TAIL_BYTE);
    // A colour packet that times out at the first tick under the limit of one second.
    send_item(1'b0, RST_HEADER_COLOR);
    send_item(1'b0, 8'h11);
    send_item(1'b1, 8'h00);
    lo = RST_TIMEOUT_LOW;
    hi = RST_TIMEOUT_HIGH;

    // Extreme register values: a zero limit times a colour packet out at its first tick,
    // and a timeout packet waits out the longest limit of 63 seconds in its tail phase.
    load_config(8'h00, 8'hFF, 8'hFF, 5'd0, 5'd31, 6'd63);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h07);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h1F);
    repeat (63) send_item(1'b1, 8'($urandom));
    // Ticks in idle run the second counter up into saturation.
    repeat (70) send_item(1'b1, 8'($urandom));
    run_random(130);

    // All header bytes equal: the colour header takes precedence over everything.
    load_config(VERSION_BYTE, VERSION_BYTE, VERSION_BYTE, 5'd31, 5'd0, 6'd1);
    run_random(120);

    // The timeout header shadows the version request, and every value is out of range.
    load_config(8'h10, VERSION_BYTE, 8'h80, 5'd31, 5'd0, 6'd2);
    run_random(120);

    // Random settings; some phases also carry the flow-control pressure cases.
    for (int p = 0; p < 5; p++) begin
      r_hc = 8'($urandom);
      load_config(r_hc, ($urandom_range(0, 3) == 0) ? r_hc : 8'($urandom), 8'($urandom),
                  5'($urandom), 5'($urandom), 6'($urandom_range(1, 63)));
      if (p == 1) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      run_random(50);
      if (p == 0) hold_requests <= hold_requests + 1;
      if (p == 2) wait_for_results();
      run_random(50);
      tx_idle_pct = 8;
      rx_idle_pct = 8;
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("summary: %0d items sent under %0d register settings, %0d results compared",
             items_sent, settings, n_checked);
    $display("summary: event codes seen (bit per code) %b", ev_seen);
    if (errors == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lcpp_pkg.sv
rtl/lcpp_core.sv
rtl/lcpp_out_buf.sv
rtl/led_command_packet_parser.sv
tb/lcpp_checker.sv
tb/tb.sv
